/* src/sem_pkg.sv */
package sem_pkg;

   localparam int unsigned PIX_W       = 8;
   localparam int unsigned FW_W        = 12;
   localparam int unsigned FH_W        = 16;
   localparam int unsigned COL_OUT_W   = 11;
   localparam int unsigned ROW_W       = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned LINE_W      = 2 * PIX_W;
   localparam int unsigned GRAD_W      = 10;
   localparam int unsigned SQ_W        = 21;
   localparam int unsigned ROOT_W      = 16;
   localparam int unsigned ROOT_STAGES = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [FW_W-1:0] FW_RESET = 12'd640;
   localparam logic [FH_W-1:0] FH_RESET = 16'd480;
   localparam int unsigned     MIN_DIM  = 3;

   localparam logic [15:0] GRAY_R_COEF = 16'd19595;
   localparam logic [15:0] GRAY_G_COEF = 16'd38470;
   localparam logic [15:0] GRAY_B_COEF = 16'd7471;

   localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

   typedef struct packed {
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 done;
   } meta_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } root_state_type;

   // one digit of the bitwise integer square root
   function automatic root_state_type sqrt_step(input root_state_type s,
                                                input logic [ROOT_W-1:0] bit_val);
      logic [ROOT_W:0] trial;
      root_state_type  r;
      trial = {1'b0, s.root} + {1'b0, bit_val};
      if ({1'b0, s.rem} >= trial) begin
         r.rem  = s.rem - trial[ROOT_W-1:0];
         r.root = (s.root >> 1) + bit_val;
      end else begin
         r.rem  = s.rem;
         r.root = s.root >> 1;
      end
      return r;
   endfunction

endpackage

/* src/sobel_edge_magnitude.sv */
// Streaming 3x3 Sobel edge magnitude. RGB pixels enter in raster order, one per
// clock when rsp_ready is held high; each accepted pixel gives its result (if any)
// in order of acceptance. Pixels whose window would leave the frame (first and last
// row and column) give no result. The two previous gray rows live in one
// MAX_WIDTH x 16-bit line store that is read and written once per pixel at the
// pixel's column; the store needs no clearing after reset. When a result is not
// taken the whole pipeline stalls and req_ready drops. Writing frame_width or
// frame_height restarts the frame at row 0, column 0; write them only while no
// request is in flight.
module sobel_edge_magnitude #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sem_pkg::PIX_W-1:0]         req_red,
   input  logic [sem_pkg::PIX_W-1:0]         req_green,
   input  logic [sem_pkg::PIX_W-1:0]         req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sem_pkg::PIX_W-1:0]         rsp_edge_level,
   output logic [sem_pkg::COL_OUT_W-1:0]     rsp_centre_col,
   output logic [sem_pkg::ROW_W-1:0]         rsp_centre_row,
   output logic                              rsp_frame_done
);

   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned WCAP_W = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CMP_W  = (WCAP_W > sem_pkg::FW_W) ? WCAP_W : sem_pkg::FW_W;

   logic [sem_pkg::FW_W-1:0]   frame_width_ff;
   logic [sem_pkg::FH_W-1:0]   frame_height_ff;
   logic [COL_W-1:0]           col_count_ff;
   logic [COL_W-1:0]           col_count_in;
   logic [sem_pkg::ROW_W-1:0]  row_count_ff;
   logic [sem_pkg::ROW_W-1:0]  row_count_in;

   logic                       s1_valid_ff;
   logic                       s1_emit_ff;
   logic [sem_pkg::PIX_W-1:0]  s1_gray_ff;
   logic [COL_W-1:0]           s1_col_ff;
   sem_pkg::meta_type          s1_meta_ff;

   logic                       rsp_valid_ff;
   logic [sem_pkg::PIX_W-1:0]  rsp_level_ff;
   sem_pkg::meta_type          rsp_meta_ff;

   logic                       advance;
   logic                       accept;
   logic                       csr_write;
   logic                       csr_known;
   logic [CMP_W-1:0]           fw_ext;
   logic [CMP_W-1:0]           eff_width;
   logic [CMP_W-1:0]           last_col;
   logic [CMP_W-1:0]           col_ext;
   logic [CMP_W-1:0]           col_m1;
   logic [sem_pkg::FH_W-1:0]   eff_height;
   logic [sem_pkg::FH_W-1:0]   last_row;
   logic                       col_at_last;
   logic                       row_at_last;
   logic                       emit;
   logic [23:0]                gray_sum;
   sem_pkg::meta_type          meta_s0;

   logic [sem_pkg::LINE_W-1:0] line_rd_data;
   logic                       line_rd_en;
   logic                       line_wr_en;
   logic [sem_pkg::LINE_W-1:0] line_wr_data;

   logic                       sq_valid;
   logic [sem_pkg::SQ_W-1:0]   sq;
   sem_pkg::meta_type          sq_meta;
   logic                       root_valid;
   logic [sem_pkg::PIX_W-1:0]  root_level;
   sem_pkg::meta_type          root_meta;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      csr_known = csr_index inside {sem_pkg::CSR_FRAME_WIDTH, sem_pkg::CSR_FRAME_HEIGHT};

      fw_ext = CMP_W'(frame_width_ff);
      if (fw_ext < CMP_W'(sem_pkg::MIN_DIM)) begin
         eff_width = CMP_W'(sem_pkg::MIN_DIM);
      end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end else begin
         eff_width = fw_ext;
      end
      eff_height = (frame_height_ff < sem_pkg::FH_W'(sem_pkg::MIN_DIM))
                   ? sem_pkg::FH_W'(sem_pkg::MIN_DIM) : frame_height_ff;

      last_col    = eff_width - CMP_W'(1);
      last_row    = eff_height - sem_pkg::FH_W'(1);
      col_ext     = CMP_W'(col_count_ff);
      col_m1      = col_ext - CMP_W'(1);
      col_at_last = col_ext == last_col;
      row_at_last = row_count_ff == last_row;
      emit        = (row_count_ff >= sem_pkg::ROW_W'(2)) && (col_ext >= CMP_W'(2));

      meta_s0.col  = col_m1[sem_pkg::COL_OUT_W-1:0];
      meta_s0.row  = row_count_ff - sem_pkg::ROW_W'(1);
      meta_s0.done = col_at_last && row_at_last;

      gray_sum = 24'(req_red)   * 24'(sem_pkg::GRAY_R_COEF)
               + 24'(req_green) * 24'(sem_pkg::GRAY_G_COEF)
               + 24'(req_blue)  * 24'(sem_pkg::GRAY_B_COEF);

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (csr_write && csr_known) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (accept) begin
         if (col_at_last) begin
            col_count_in = '0;
            row_count_in = row_at_last ? '0 : row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sem_pkg::FW_RESET;
         frame_height_ff <= sem_pkg::FH_RESET;
         col_count_ff    <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               sem_pkg::CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_data[sem_pkg::FW_W-1:0];
               end
               sem_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_data[sem_pkg::FH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            rsp_valid_ff <= root_valid;
         end
      end
      if (advance) begin
         s1_emit_ff <= emit;
         s1_gray_ff <= gray_sum[23:16];
         s1_col_ff  <= col_count_ff;
         s1_meta_ff <= meta_s0;
         if (root_valid) begin
            rsp_level_ff <= root_level;
            rsp_meta_ff  <= root_meta;
         end
      end
   end

   // entry = {row two above, row above}
   assign line_rd_en   = accept;
   assign line_wr_en   = s1_valid_ff && advance;
   assign line_wr_data = {line_rd_data[sem_pkg::PIX_W-1:0], s1_gray_ff};

   sem_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (line_rd_en),
      .rd_addr (col_count_ff),
      .rd_data (line_rd_data),
      .wr_en   (line_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr_data)
   );

   sem_grad u_grad (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .col_valid  (s1_valid_ff),
      .result_req (s1_emit_ff),
      .top        (line_rd_data[sem_pkg::LINE_W-1:sem_pkg::PIX_W]),
      .mid        (line_rd_data[sem_pkg::PIX_W-1:0]),
      .bot        (s1_gray_ff),
      .meta_in    (s1_meta_ff),
      .sq_valid   (sq_valid),
      .sq         (sq),
      .meta_out   (sq_meta)
   );

   sem_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_sq     (sq),
      .meta_in   (sq_meta),
      .out_valid (root_valid),
      .out_level (root_level),
      .meta_out  (root_meta)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_level = rsp_level_ff;
   assign rsp_centre_col = rsp_meta_ff.col;
   assign rsp_centre_row = rsp_meta_ff.row;
   assign rsp_frame_done = rsp_meta_ff.done;

   a_line_collision: assert property (@(posedge clock) disable iff (reset)
      (line_wr_en && line_rd_en) |-> (s1_col_ff != col_count_ff))
      else $error("line store read and write hit the same column");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ext < eff_width)
      else $error("column counter beyond frame width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_count_ff < eff_height)
      else $error("row counter beyond frame height");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_known) |=> (col_count_ff == '0 && row_count_ff == '0))
      else $error("register write did not restart the frame");

   a_centre_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_meta_ff.row != '0))
      else $error("result centred on the first row");

endmodule

/* src/sem_line_store.sv */
module sem_line_store #(
   parameter  int unsigned DEPTH  = 2048,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [sem_pkg::LINE_W-1:0]   rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [sem_pkg::LINE_W-1:0]   wr_data
);

   logic [sem_pkg::LINE_W-1:0] lines_ff [0:DEPTH-1];
   logic [sem_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lines_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= lines_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sem_grad.sv */
module sem_grad (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         col_valid,
   input  logic                         result_req,
   input  logic [sem_pkg::PIX_W-1:0]    top,
   input  logic [sem_pkg::PIX_W-1:0]    mid,
   input  logic [sem_pkg::PIX_W-1:0]    bot,
   input  sem_pkg::meta_type            meta_in,
   output logic                         sq_valid,
   output logic [sem_pkg::SQ_W-1:0]     sq,
   output sem_pkg::meta_type            meta_out
);

   logic [sem_pkg::PIX_W-1:0]  taps_ff [0:8];
   logic                       a_valid_ff;
   sem_pkg::meta_type          a_meta_ff;
   logic                       b_valid_ff;
   logic [sem_pkg::GRAD_W-1:0] ax_ff;
   logic [sem_pkg::GRAD_W-1:0] ay_ff;
   sem_pkg::meta_type          b_meta_ff;
   logic                       c_valid_ff;
   logic [sem_pkg::SQ_W-1:0]   sq_ff;
   sem_pkg::meta_type          c_meta_ff;

   logic signed [10:0]         t [0:8];
   logic signed [10:0]         gx;
   logic signed [10:0]         gy;
   logic signed [10:0]         gx_neg;
   logic signed [10:0]         gy_neg;
   logic [sem_pkg::GRAD_W-1:0] ax_in;
   logic [sem_pkg::GRAD_W-1:0] ay_in;
   logic [2*sem_pkg::GRAD_W-1:0] sqx;
   logic [2*sem_pkg::GRAD_W-1:0] sqy;
   logic [sem_pkg::SQ_W-1:0]   sq_in;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         t[i] = signed'({3'b000, taps_ff[i]});
      end
      gx = t[2] - t[0] + (t[5] <<< 1) - (t[3] <<< 1) + t[8] - t[6];
      gy = t[6] + (t[7] <<< 1) + t[8] - t[0] - (t[1] <<< 1) - t[2];
      gx_neg = -gx;
      gy_neg = -gy;
      ax_in  = gx[10] ? gx_neg[sem_pkg::GRAD_W-1:0] : gx[sem_pkg::GRAD_W-1:0];
      ay_in  = gy[10] ? gy_neg[sem_pkg::GRAD_W-1:0] : gy[sem_pkg::GRAD_W-1:0];
      sqx    = ax_ff * ax_ff;
      sqy    = ay_ff * ay_ff;
      sq_in  = {1'b0, sqx} + {1'b0, sqy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= col_valid && result_req;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         if (col_valid) begin
            for (int k = 0; k < 3; k++) begin
               taps_ff[k*3]   <= taps_ff[k*3+1];
               taps_ff[k*3+1] <= taps_ff[k*3+2];
            end
            taps_ff[2] <= top;
            taps_ff[5] <= mid;
            taps_ff[8] <= bot;
         end
         a_meta_ff <= meta_in;
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         b_meta_ff <= a_meta_ff;
         sq_ff     <= sq_in;
         c_meta_ff <= b_meta_ff;
      end
   end

   assign sq_valid = c_valid_ff;
   assign sq       = sq_ff;
   assign meta_out = c_meta_ff;

endmodule

/* src/sem_sqrt.sv */
module sem_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [sem_pkg::SQ_W-1:0]     in_sq,
   input  sem_pkg::meta_type            meta_in,
   output logic                         out_valid,
   output logic [sem_pkg::PIX_W-1:0]    out_level,
   output sem_pkg::meta_type            meta_out
);

   localparam int unsigned NS = sem_pkg::ROOT_STAGES;

   logic [NS-1:0]              valid_ff;
   logic [NS-1:0]              sat_ff;
   sem_pkg::root_state_type    st_ff   [0:NS-1];
   sem_pkg::meta_type          meta_ff [0:NS-1];
   sem_pkg::root_state_type    st_src  [0:NS-1];
   sem_pkg::root_state_type    st_in   [0:NS-1];
   logic                       in_sat;

   assign in_sat = in_sq[sem_pkg::SQ_W-1:sem_pkg::ROOT_W] != '0;

   always_comb begin
      st_src[0].rem  = in_sq[sem_pkg::ROOT_W-1:0];
      st_src[0].root = '0;
      for (int j = 1; j < NS; j++) begin
         st_src[j] = st_ff[j-1];
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam logic [sem_pkg::ROOT_W-1:0] BIT_HI = 16'(1) << (2 * (7 - 2 * j));
      localparam logic [sem_pkg::ROOT_W-1:0] BIT_LO = 16'(1) << (2 * (6 - 2 * j));
      assign st_in[j] = sem_pkg::sqrt_step(sem_pkg::sqrt_step(st_src[j], BIT_HI), BIT_LO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
      if (advance) begin
         sat_ff     <= {sat_ff[NS-2:0], in_sat};
         meta_ff[0] <= meta_in;
         for (int j = 0; j < NS; j++) begin
            st_ff[j] <= st_in[j];
         end
         for (int j = 1; j < NS; j++) begin
            meta_ff[j] <= meta_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_level = sat_ff[NS-1] ? sem_pkg::LEVEL_MAX
                                   : st_ff[NS-1].root[sem_pkg::PIX_W-1:0];
   assign meta_out  = meta_ff[NS-1];

endmodule

/* sim/sobel_edge_magnitude_test.sv */
`timescale 1ns / 100ps

module sobel_edge_magnitude_test;

   localparam int unsigned MAX_COLS       = 2048;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned HOLD_CYCLES    = 100;
   localparam int unsigned RANDOM_ITEMS   = 250;
   localparam int unsigned DIRECTED_COUNT = 27;

   localparam logic [sem_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sem_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [sem_pkg::PIX_W-1:0]     level;
      logic [sem_pkg::COL_OUT_W-1:0] col;
      logic [sem_pkg::ROW_W-1:0]     row;
      logic                          done;
   } edge_type;

   typedef struct packed {
      logic [sem_pkg::PIX_W-1:0] red;
      logic [sem_pkg::PIX_W-1:0] green;
      logic [sem_pkg::PIX_W-1:0] blue;
      logic                      poke_spare;
      logic                      typed;
      edge_type                  want;
   } pixel_vec_type;

   localparam edge_type NO_EDGE   = '0;
   localparam edge_type FLAT_EDGE = '{level: 8'd0, col: 11'd1, row: 16'd1, done: 1'b1};
   localparam edge_type STEP_EDGE = '{level: 8'd255, col: 11'd1, row: 16'd1, done: 1'b1};

   // 3x3 frames: flat white, then a black-to-white step, then mixed channels
   localparam pixel_vec_type DIRECTED_PIXELS [DIRECTED_COUNT] = '{
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, FLAT_EDGE},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, NO_EDGE},
      '{8'd128, 8'd128, 8'd128, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, NO_EDGE},
      '{8'd128, 8'd128, 8'd128, 1'b1, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, NO_EDGE},
      '{8'd128, 8'd128, 8'd128, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, STEP_EDGE},
      '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, NO_EDGE},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, NO_EDGE},
      '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, NO_EDGE},
      '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, NO_EDGE},
      '{8'd1,   8'd2,   8'd4,   1'b0, 1'b0, NO_EDGE},
      '{8'd128, 8'd64,  8'd32,  1'b0, 1'b0, NO_EDGE},
      '{8'd254, 8'd253, 8'd127, 1'b0, 1'b0, NO_EDGE}
   };

   logic                           clock;
   logic                           reset          = 1'b1;
   logic                           csr_valid      = 1'b0;
   logic                           csr_ready;
   logic [sem_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [sem_pkg::CSR_DATA_W-1:0] csr_data       = '0;
   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic [sem_pkg::PIX_W-1:0]      req_red        = '0;
   logic [sem_pkg::PIX_W-1:0]      req_green      = '0;
   logic [sem_pkg::PIX_W-1:0]      req_blue       = '0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic [sem_pkg::PIX_W-1:0]      rsp_edge_level;
   logic [sem_pkg::COL_OUT_W-1:0]  rsp_centre_col;
   logic [sem_pkg::ROW_W-1:0]      rsp_centre_row;
   logic                           rsp_frame_done;

   // predictor state
   logic [sem_pkg::FW_W-1:0]  geom_width  = sem_pkg::FW_RESET;
   logic [sem_pkg::FH_W-1:0]  geom_height = sem_pkg::FH_RESET;
   logic [sem_pkg::PIX_W-1:0] line_top [MAX_COLS] = '{default: 8'd0};
   logic [sem_pkg::PIX_W-1:0] line_mid [MAX_COLS] = '{default: 8'd0};
   int unsigned               tap [9] = '{default: 0};
   int unsigned               col_pos = 0;
   int unsigned               row_pos = 0;

   edge_type    pending_edges [$];
   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 45;
   int unsigned hold_left     = 0;
   bit          hold_request  = 1'b0;

   sobel_edge_magnitude #(
      .MAX_WIDTH (MAX_COLS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_level (rsp_edge_level),
      .rsp_centre_col (rsp_centre_col),
      .rsp_centre_row (rsp_centre_row),
      .rsp_frame_done (rsp_frame_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic predict_edge(input logic [sem_pkg::PIX_W-1:0] r, g, b,
                               output bit found, output edge_type res);
      int unsigned gray, w, h, c, top, mid, sq, root;
      int          gx, gy;
      gray = (19595 * int'(r) + 38470 * int'(g) + 7471 * int'(b)) >> 16;
      w = (geom_width < 3) ? 3 : ((geom_width > MAX_COLS) ? MAX_COLS : geom_width);
      h = (geom_height < 3) ? 3 : geom_height;
      c = col_pos;
      top = line_top[c];
      mid = line_mid[c];
      line_top[c] = mid[sem_pkg::PIX_W-1:0];
      line_mid[c] = gray[sem_pkg::PIX_W-1:0];
      for (int k = 0; k < 3; k++) begin
         tap[k*3]   = tap[k*3+1];
         tap[k*3+1] = tap[k*3+2];
      end
      tap[2] = top;
      tap[5] = mid;
      tap[8] = gray;
      found = 1'b0;
      res   = '0;
      if (row_pos >= 2 && c >= 2) begin
         gx = -int'(tap[0]) + int'(tap[2]) - 2 * int'(tap[3]) + 2 * int'(tap[5])
              - int'(tap[6]) + int'(tap[8]);
         gy = -int'(tap[0]) - 2 * int'(tap[1]) - int'(tap[2])
              + int'(tap[6]) + 2 * int'(tap[7]) + int'(tap[8]);
         sq = gx * gx + gy * gy;
         root = 0;
         while (root < 255 && (root + 1) * (root + 1) <= sq) root++;
         res.level = root[sem_pkg::PIX_W-1:0];
         res.col   = sem_pkg::COL_OUT_W'(c - 1);
         res.row   = sem_pkg::ROW_W'(row_pos - 1);
         res.done  = (c == w - 1) && (row_pos == h - 1);
         found = 1'b1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      col_pos = c;
   endtask

   task automatic send_pixel(input logic [sem_pkg::PIX_W-1:0] r, g, b,
                             input bit typed, input edge_type typed_res);
      bit       found;
      edge_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
      predict_edge(r, g, b, found, res);
      if (typed) pending_edges.push_back(typed_res);
      else if (found) pending_edges.push_back(res);
   endtask

   // only while idle: drain results, then let the pipeline empty out
   task automatic write_reg(input logic [sem_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sem_pkg::CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sem_pkg::CSR_FRAME_WIDTH: begin
            geom_width = data[sem_pkg::FW_W-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         sem_pkg::CSR_FRAME_HEIGHT: begin
            geom_height = data[sem_pkg::FH_W-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         default: ;
      endcase
   endtask

   function automatic logic [sem_pkg::PIX_W-1:0] rand_channel(input bit harsh);
      if (!harsh) return sem_pkg::PIX_W'($urandom);
      case ($urandom_range(2))
         0: return 8'd0;
         1: return 8'd255;
         default: return sem_pkg::PIX_W'($urandom);
      endcase
   endfunction

   task automatic send_random(input int unsigned count);
      bit harsh;
      for (int unsigned i = 0; i < count; i++) begin
         harsh = 1'($urandom_range(1));
         send_pixel(rand_channel(harsh), rand_channel(harsh), rand_channel(harsh),
                    1'b0, NO_EDGE);
      end
   endtask

   // result checker and receiver back-pressure
   initial begin
      edge_type want;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_edges.size() == 0) begin
               $error("unexpected result: level %0d col %0d row %0d done %0d",
                      rsp_edge_level, rsp_centre_col, rsp_centre_row, rsp_frame_done);
               error_count++;
            end else begin
               want = pending_edges.pop_front();
               if (rsp_edge_level !== want.level) begin
                  $error("edge_level: expected %0d, got %0d", want.level, rsp_edge_level);
                  error_count++;
               end
               if (rsp_centre_col !== want.col) begin
                  $error("centre_col: expected %0d, got %0d", want.col, rsp_centre_col);
                  error_count++;
               end
               if (rsp_centre_row !== want.row) begin
                  $error("centre_row: expected %0d, got %0d", want.row, rsp_centre_row);
                  error_count++;
               end
               if (rsp_frame_done !== want.done) begin
                  $error("frame_done: expected %0d, got %0d", want.done, rsp_frame_done);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned               sent, burst;
      logic [sem_pkg::FW_W-1:0]  w;
      logic [sem_pkg::FH_W-1:0]  h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: first pixels of the default frame, no result yet
      send_random(10);

      // directed, 3x3 frames from clamped zero sizes
      write_reg(sem_pkg::CSR_FRAME_WIDTH, 16'd0);
      write_reg(sem_pkg::CSR_FRAME_HEIGHT, 16'd0);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_PIXELS[i].poke_spare) write_reg(CSR_SPARE_2, 16'hFFFF);
         send_pixel(DIRECTED_PIXELS[i].red, DIRECTED_PIXELS[i].green,
                    DIRECTED_PIXELS[i].blue, DIRECTED_PIXELS[i].typed,
                    DIRECTED_PIXELS[i].want);
      end

      // widest frame, width clamped down to the line store size, first row only
      write_reg(sem_pkg::CSR_FRAME_WIDTH, 16'd4095);
      write_reg(sem_pkg::CSR_FRAME_HEIGHT, 16'd3);
      send_random(20);

      // tallest frame, narrowest width
      write_reg(sem_pkg::CSR_FRAME_HEIGHT, 16'hFFFF);
      write_reg(sem_pkg::CSR_FRAME_WIDTH, 16'd1);
      send_random(30);

      // long receiver stall with the sender pushing
      write_reg(sem_pkg::CSR_FRAME_WIDTH, 16'd5);
      write_reg(sem_pkg::CSR_FRAME_HEIGHT, 16'd4);
      send_idle_pct = 0;
      hold_request  = 1'b1;
      send_random(60);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 45;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 45;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         w = ($urandom_range(9) == 0) ? sem_pkg::FW_W'($urandom_range(2))
                                      : sem_pkg::FW_W'($urandom_range(3, 10));
         h = ($urandom_range(9) == 0) ? sem_pkg::FH_W'($urandom_range(2))
                                      : sem_pkg::FH_W'($urandom_range(3, 7));
         if ($urandom_range(4) == 0)
            write_reg($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      sem_pkg::CSR_DATA_W'($urandom));
         if ($urandom_range(1)) begin
            write_reg(sem_pkg::CSR_FRAME_WIDTH, {4'($urandom), w});
            write_reg(sem_pkg::CSR_FRAME_HEIGHT, h);
         end else begin
            write_reg(sem_pkg::CSR_FRAME_HEIGHT, h);
            write_reg(sem_pkg::CSR_FRAME_WIDTH, {4'($urandom), w});
         end
         burst = $urandom_range(15, 60);
         send_random(burst);
         sent += burst;
      end

      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/sem_pkg.sv
src/sem_line_store.sv
src/sem_grad.sv
src/sem_sqrt.sv
src/sobel_edge_magnitude.sv
sim/sobel_edge_magnitude_test.sv
